// ----- src/u8nl_pkg.sv -----
// Shared types and constants for the UTF-8 validator with newline normalization.
`default_nettype none
package u8nl_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_BYTE = 2'd1;
  localparam logic [1:0] ERR_RANGE    = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  localparam logic [7:0]  CHAR_CR = 8'h0D;
  localparam logic [7:0]  CHAR_LF = 8'h0A;

  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;

  localparam logic [16:0] MIN_CP2 = 17'h00080;
  localparam logic [16:0] MIN_CP3 = 17'h00800;
  localparam logic [16:0] MIN_CP4 = 17'h10000;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keep;
    logic [1:0] error_kind;
    logic       end_flag;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        stream_end;
    byte_class_t cls;
    logic        raw;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ----- src/utf8_validate_newline_normalize.sv -----
// Top level of the strict UTF-8 validator with CR/LF normalization.
// One result per input byte, one byte per clock sustained while out_stall
// stays low. A byte's result is held in the queue and then registered in
// the output register; the per-byte decode step in the back end sets that rate.
// A queue of QUEUE_DEPTH entries sits between classification and decode so
// the input keeps taking bytes for a while after the output stalls. The
// error code is sticky until the byte flagged stream_end; that byte clears
// all stream state. cfg_data sets the raw mode register; write it only while idle.
`default_nettype none
module utf8_validate_newline_normalize
  import u8nl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  q_status_t q_stat;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  u8nl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  u8nl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  u8nl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_trunc_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_kind == ERR_TRUNC |-> out_data.end_flag)
    else $error("truncation reported before end of stream");

  a_drop_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.keep |-> out_data.out_byte == CHAR_LF)
    else $error("dropped byte is not LF");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("decoded transfer lost at output register");

endmodule
`default_nettype wire

// ----- src/u8nl_front.sv -----
// Front end: input transfer, byte classification and the raw mode register.
`default_nettype none
module u8nl_front
  import u8nl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data,
  input  wire q_status_t q_stat,
  output logic           push,
  output q_entry_t       push_entry
);

  logic raw;

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t k;
    priority if (c < 8'h80) begin
      k = CLS_ASCII;
    end else if (c < 8'hC0) begin
      k = CLS_CONT;
    end else if (c < 8'hC2) begin
      k = CLS_BAD;
    end else if (c < 8'hE0) begin
      k = CLS_LEAD2;
    end else if (c < 8'hF0) begin
      k = CLS_LEAD3;
    end else if (c < 8'hF5) begin
      k = CLS_LEAD4;
    end else begin
      k = CLS_BAD;
    end
    return k;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw <= 1'b0;
    end else if (cfg_valid) begin
      raw <= cfg_data;
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_entry.data_byte  = in_data.data_byte;
    push_entry.stream_end = in_data.stream_end;
    push_entry.cls        = classify(in_data.data_byte);
    push_entry.raw        = raw;
  end

endmodule
`default_nettype wire

// ----- src/u8nl_queue.sv -----
// Short show-ahead queue between the front end and the decoder.
`default_nettype none
module u8nl_queue
  import u8nl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_status_t     q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/u8nl_back.sv -----
// Back end: UTF-8 sequence tracking, CR/LF rewriting and the output register.
`default_nettype none
module u8nl_back
  import u8nl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_entry_t  head,
  input  wire q_status_t q_stat,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [1:0]  pend, pend_next;
  logic [20:0] acc, acc_next;
  logic [16:0] lb, lb_next;
  logic        after_cr, after_cr_next;
  logic [1:0]  err, err_next;
  logic [1:0]  new_err;
  out_item_t   result;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_comb begin
    pend_next     = pend;
    acc_next      = acc;
    lb_next       = lb;
    after_cr_next = after_cr;
    new_err       = ERR_NONE;
    result.out_byte = head.data_byte;
    result.keep     = 1'b1;
    result.end_flag = head.stream_end;

    if (!head.raw) begin
      if (pend != 2'd0) begin
        if (head.cls != CLS_CONT) begin
          new_err   = ERR_BAD_BYTE;
          pend_next = 2'd0;
          acc_next  = '0;
          lb_next   = '0;
        end else begin
          acc_next  = {acc[14:0], head.data_byte[5:0]};
          pend_next = pend - 2'd1;
          if (pend_next == 2'd0 &&
              (acc_next < {4'd0, lb} || acc_next > CP_MAX ||
               (acc_next >= SURR_LO && acc_next <= SURR_HI))) begin
            new_err = ERR_RANGE;
          end
        end
      end else begin
        unique case (head.cls)
          CLS_ASCII: begin
          end
          CLS_LEAD2: begin
            pend_next = 2'd1;
            acc_next  = {16'd0, head.data_byte[4:0]};
            lb_next   = MIN_CP2;
          end
          CLS_LEAD3: begin
            pend_next = 2'd2;
            acc_next  = {17'd0, head.data_byte[3:0]};
            lb_next   = MIN_CP3;
          end
          CLS_LEAD4: begin
            pend_next = 2'd3;
            acc_next  = {18'd0, head.data_byte[2:0]};
            lb_next   = MIN_CP4;
          end
          default: begin
            new_err = ERR_BAD_BYTE;
          end
        endcase
      end

      if (head.data_byte == CHAR_CR) begin
        result.out_byte = CHAR_LF;
        after_cr_next   = 1'b1;
      end else if (head.data_byte == CHAR_LF && after_cr) begin
        result.keep   = 1'b0;
        after_cr_next = 1'b0;
      end else begin
        after_cr_next = 1'b0;
      end

      if (head.stream_end && pend_next != 2'd0 && new_err == ERR_NONE) begin
        new_err = ERR_TRUNC;
      end
    end

    // first error wins
    err_next = (err != ERR_NONE) ? err : new_err;
    result.error_kind = err_next;

    if (head.stream_end) begin
      pend_next     = 2'd0;
      acc_next      = '0;
      lb_next       = '0;
      after_cr_next = 1'b0;
      err_next      = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 2'd0;
      acc       <= '0;
      lb        <= '0;
      after_cr  <= 1'b0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pend      <= pend_next;
        acc       <= acc_next;
        lb        <= lb_next;
        after_cr  <= after_cr_next;
        err       <= err_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for utf8_validate_newline_normalize: directed and random streams, checked.
module testbench;
  import u8nl_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  utf8_validate_newline_normalize dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  in_item_t    pending_bytes_q[$];
  out_item_t   expected_out_q[$];
  logic [7:0]  stream_bytes[$];
  int unsigned gap_pct = 34;
  int unsigned stall_pct = 34;
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;

  // predictor state
  logic        raw_mode = 1'b0;
  logic [1:0]  cont_left = '0;
  logic [20:0] cp_acc = '0;
  logic [16:0] cp_floor = '0;
  logic        prev_cr = 1'b0;
  logic [1:0]  sticky_err = ERR_NONE;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void latch_err(logic [1:0] kind);
    if (sticky_err == ERR_NONE) sticky_err = kind;
  endfunction

  function automatic out_item_t normalize_byte(in_item_t it);
    out_item_t  r;
    logic [7:0] c;
    c = it.data_byte;
    r.out_byte = c;
    r.keep = 1'b1;
    if (!raw_mode) begin
      if (cont_left != 2'd0) begin
        if (c[7:6] != 2'b10) begin
          latch_err(ERR_BAD_BYTE);
          cont_left = '0;
          cp_acc = '0;
          cp_floor = '0;
        end else begin
          cp_acc = {cp_acc[14:0], c[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0 && (cp_acc < {4'b0, cp_floor} || cp_acc > CP_MAX ||
              (cp_acc >= SURR_LO && cp_acc <= SURR_HI)))
            latch_err(ERR_RANGE);
        end
      end else if (c[7]) begin
        if (c >= 8'hC2 && c <= 8'hDF) begin
          cont_left = 2'd1;
          cp_acc = {16'b0, c[4:0]};
          cp_floor = MIN_CP2;
        end else if (c >= 8'hE0 && c <= 8'hEF) begin
          cont_left = 2'd2;
          cp_acc = {17'b0, c[3:0]};
          cp_floor = MIN_CP3;
        end else if (c >= 8'hF0 && c <= 8'hF4) begin
          cont_left = 2'd3;
          cp_acc = {18'b0, c[2:0]};
          cp_floor = MIN_CP4;
        end else begin
          latch_err(ERR_BAD_BYTE);
        end
      end
      if (c == CHAR_CR) begin
        r.out_byte = CHAR_LF;
        prev_cr = 1'b1;
      end else if (c == CHAR_LF && prev_cr) begin
        r.keep = 1'b0;
        prev_cr = 1'b0;
      end else begin
        prev_cr = 1'b0;
      end
      if (it.stream_end && cont_left != 2'd0) latch_err(ERR_TRUNC);
    end
    r.error_kind = sticky_err;
    r.end_flag = it.stream_end;
    if (it.stream_end) begin
      cont_left = '0;
      cp_acc = '0;
      cp_floor = '0;
      prev_cr = 1'b0;
      sticky_err = ERR_NONE;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("mismatch: %s", what);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_out_q.insert(expected_out_q.size(), normalize_byte(in_data));
        void'(pending_bytes_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_bytes_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_bytes_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data));
        end else begin
          out_item_t exp_r;
          exp_r = expected_out_q.pop_front();
          if (out_data.out_byte !== exp_r.out_byte)
            report_mismatch($sformatf("result %0d out_byte %h, expected %h",
                                      results_seen, out_data.out_byte, exp_r.out_byte));
          if (out_data.keep !== exp_r.keep)
            report_mismatch($sformatf("result %0d keep %b, expected %b",
                                      results_seen, out_data.keep, exp_r.keep));
          if (out_data.error_kind !== exp_r.error_kind)
            report_mismatch($sformatf("result %0d error_kind %0d, expected %0d",
                                      results_seen, out_data.error_kind, exp_r.error_kind));
          if (out_data.end_flag !== exp_r.end_flag)
            report_mismatch($sformatf("result %0d end_flag %b, expected %b",
                                      results_seen, out_data.end_flag, exp_r.end_flag));
        end
        results_seen++;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // stream building
  function automatic void add_byte(logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  function automatic void flush_stream(bit close);
    foreach (stream_bytes[i])
      pending_bytes_q.insert(pending_bytes_q.size(),
                             {stream_bytes[i], close && i == stream_bytes.size() - 1});
    stream_bytes.delete();
  endfunction

  function automatic void add_cp(logic [20:0] cp, int unsigned len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_valid_cp(int unsigned len);
    int unsigned lo;
    int unsigned hi;
    logic [20:0] cp;
    case (len)
      2: begin lo = 'h80; hi = 'h7FF; end
      3: begin lo = 'h800; hi = 'hFFFF; end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    if ($urandom_range(0, 7) == 0) cp = 21'($urandom_range(0, 1) ? hi : lo);
    else cp = 21'($urandom_range(hi, lo));
    if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h3000;
    add_cp(cp, len);
  endfunction

  // multi-byte sequence missing its tail
  function automatic void add_cut_seq();
    int unsigned len;
    int unsigned drop;
    len = $urandom_range(2, 4);
    add_valid_cp(len);
    drop = $urandom_range(1, len - 1);
    repeat (drop) void'(stream_bytes.pop_back());
  endfunction

  function automatic void add_good_unit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      add_byte(8'($urandom_range(0, 127)));
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0: add_byte(CHAR_CR);
        1: add_byte(CHAR_LF);
        2: begin
          add_byte(CHAR_CR);
          add_byte(CHAR_LF);
        end
        default: begin
          add_byte(CHAR_CR);
          add_byte(CHAR_CR);
          add_byte(CHAR_LF);
        end
      endcase
    end else begin
      add_valid_cp($urandom_range(2, 4));
    end
  endfunction

  function automatic void add_bad_unit();
    int unsigned len;
    case ($urandom_range(0, 5))
      0: add_byte(8'($urandom_range(0, 255)));
      1: add_byte(8'($urandom_range('hBF, 'h80)));
      2: begin
        len = $urandom_range(2, 4);
        add_cp(21'($urandom_range(len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF, 0)), len);
      end
      3: add_cp(21'($urandom_range(SURR_HI, SURR_LO)), 3);
      4: add_cp(21'($urandom_range('h1FFFFF, 'h110000)), 4);
      default: add_cut_seq();
    endcase
  endfunction

  function automatic void build_stream(bit clean);
    int unsigned units;
    units = $urandom_range(1, 10);
    repeat (units) begin
      if (clean || $urandom_range(0, 99) < 70) add_good_unit();
      else add_bad_unit();
    end
    if (!clean && $urandom_range(0, 5) == 0) add_cut_seq();
  endfunction

  task automatic random_phase(int unsigned n_bytes, bit leave_open);
    int unsigned pushed;
    pushed = 0;
    while (pushed < n_bytes) begin
      build_stream($urandom_range(0, 99) < 55);
      pushed += stream_bytes.size();
      flush_stream(1'b1);
    end
    // leave a stream open across the next register write
    if (leave_open) begin
      add_byte($urandom_range(0, 1) ? CHAR_CR : 8'($urandom_range('hF4, 'hC2)));
      flush_stream(1'b0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes_q.size() != 0 || expected_out_q.size() != 0);
  endtask

  task automatic write_raw(logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    raw_mode = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    stream_bytes = '{8'h00, 8'h7F, 8'h0D, 8'h0A, 8'h0A, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'hED, 8'hA0, 8'h80, 8'hC0, 8'hFF};
    flush_stream(1'b1);
    stream_bytes = '{8'hE2, 8'h0D, 8'h0A, 8'hF0, 8'h90};
    flush_stream(1'b1);
    stream_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    flush_stream(1'b1);
    stream_bytes = '{8'hE0, 8'hA0};
    flush_stream(1'b1);
    wait_drained();

    write_raw(1'b0);
    random_phase(600, 1'b1);
    wait_drained();

    write_raw(1'b1);
    random_phase(250, 1'b1);
    wait_drained();

    write_raw(1'b0);
    gap_pct = 0;
    stall_pct = 0;
    random_phase(500, 1'b1);
    wait_drained();

    gap_pct = 34;
    stall_pct = 34;
    write_raw(1'b1);
    random_phase(60, 1'b1);
    wait_drained();

    write_raw(1'b0);
    random_phase(600, 1'b0);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/u8nl_pkg.sv
src/u8nl_front.sv
src/u8nl_queue.sv
src/u8nl_back.sv
src/utf8_validate_newline_normalize.sv
tb/testbench.sv
